// ===== sv/frx_pkg.sv =====
// Shared types and constants for the length-prefixed frame receiver.
// Used by frx_cfg, frx_parse and prefixed_frame_receiver; depends on nothing.
`timescale 1ns / 1ps

package frx_pkg;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [7:0] PREFIX_VALUE_RST  = 8'd170;
  localparam logic [3:0] PREFIX_LENGTH_RST = 4'd2;
  localparam logic [3:0] PREFIX_LENGTH_MIN = 4'd2;

  // Register index, taken from paddr[2].
  localparam logic REG_PREFIX_VALUE  = 1'b0;
  localparam logic REG_PREFIX_LENGTH = 1'b1;

  typedef struct packed {
    logic [7:0] prefix_value;
    logic [3:0] prefix_length;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_HUNT    = 4'b0001,
    ST_LEN_HI  = 4'b0010,
    ST_LEN_LO  = 4'b0100,
    ST_PAYLOAD = 4'b1000
  } state_t;

  typedef struct packed {
    logic        emit;
    logic [7:0]  payload_byte;
    logic        last_of_frame;
    logic        check_ok;
    logic [15:0] frame_count;
  } res_t;

endpackage

// ===== sv/frx_cfg.sv =====
// Configuration registers of the frame receiver behind an APB-style port.
// Depends on frx_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module frx_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [frx_pkg::ADDR_W-1:0]  paddr,
  input  logic [frx_pkg::DATA_W-1:0]  pwdata,
  output logic [frx_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output frx_pkg::cfg_t               cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prefix_value  <= frx_pkg::PREFIX_VALUE_RST;
      cfg.prefix_length <= frx_pkg::PREFIX_LENGTH_RST;
    end else if (wr_en) begin
      case (paddr[2])
        frx_pkg::REG_PREFIX_VALUE:  cfg.prefix_value  <= pwdata[7:0];
        frx_pkg::REG_PREFIX_LENGTH: cfg.prefix_length <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      frx_pkg::REG_PREFIX_VALUE:  prdata = {{(frx_pkg::DATA_W-8){1'b0}}, cfg.prefix_value};
      frx_pkg::REG_PREFIX_LENGTH: prdata = {{(frx_pkg::DATA_W-4){1'b0}}, cfg.prefix_length};
      default:                    prdata = '0;
    endcase
  end

endmodule

// ===== sv/frx_parse.sv =====
// Frame parser: prefix hunt, length capture, payload XOR check and pass counter.
// Depends on frx_pkg for cfg_t, state_t and res_t.
`timescale 1ns / 1ps

module frx_parse (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    rx_byte,
  input  frx_pkg::cfg_t cfg,
  output frx_pkg::res_t res
);

  frx_pkg::state_t state, state_next;
  logic [3:0]  prefix_run, prefix_run_next;
  logic [7:0]  previous_rx;
  logic [7:0]  length_high, length_high_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] data_idx, data_idx_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [15:0] good_frames, good_frames_next;

  logic [3:0]  plen;
  logic [3:0]  run_upd;
  logic [15:0] flen_rx;
  logic [16:0] idx_plus;
  logic        last;
  logic        ok;

  always_comb begin
    plen     = (cfg.prefix_length < frx_pkg::PREFIX_LENGTH_MIN) ?
               frx_pkg::PREFIX_LENGTH_MIN : cfg.prefix_length;
    flen_rx  = {length_high, rx_byte};
    idx_plus = {1'b0, data_idx} + 17'd1;
    last     = (idx_plus == {1'b0, frame_length});
    ok       = last && ((frame_length == 16'd1) || (running_xor == rx_byte));

    // A prefix byte only extends the run when the byte before it was one too.
    if (rx_byte == cfg.prefix_value) begin
      run_upd = (previous_rx == cfg.prefix_value) ? prefix_run + 4'd1 : prefix_run;
    end else begin
      run_upd = 4'd0;
    end

    state_next        = state;
    prefix_run_next   = prefix_run;
    length_high_next  = length_high;
    frame_length_next = frame_length;
    data_idx_next     = data_idx;
    running_xor_next  = running_xor;
    good_frames_next  = good_frames;

    res.emit          = 1'b0;
    res.payload_byte  = rx_byte;
    res.last_of_frame = 1'b0;
    res.check_ok      = 1'b0;
    res.frame_count   = good_frames;

    case (state)
      frx_pkg::ST_HUNT: begin
        prefix_run_next = run_upd;
        if (run_upd == plen - 4'd1) begin
          state_next       = frx_pkg::ST_LEN_HI;
          running_xor_next = 8'd0;
        end
      end
      frx_pkg::ST_LEN_HI: begin
        length_high_next = rx_byte;
        state_next       = frx_pkg::ST_LEN_LO;
      end
      frx_pkg::ST_LEN_LO: begin
        if (flen_rx == 16'd0) begin
          state_next        = frx_pkg::ST_HUNT;
          prefix_run_next   = 4'd0;
          length_high_next  = 8'd0;
          frame_length_next = 16'd0;
          running_xor_next  = 8'd0;
        end else begin
          state_next        = frx_pkg::ST_PAYLOAD;
          frame_length_next = flen_rx;
          data_idx_next     = 16'd0;
        end
      end
      frx_pkg::ST_PAYLOAD: begin
        good_frames_next  = good_frames + {15'd0, ok};
        res.emit          = 1'b1;
        res.last_of_frame = last;
        res.check_ok      = ok;
        res.frame_count   = good_frames_next;
        if (last) begin
          state_next        = frx_pkg::ST_HUNT;
          prefix_run_next   = 4'd0;
          length_high_next  = 8'd0;
          frame_length_next = 16'd0;
          running_xor_next  = 8'd0;
          data_idx_next     = 16'd0;
        end else begin
          running_xor_next = running_xor ^ rx_byte;
          data_idx_next    = idx_plus[15:0];
        end
      end
      default: begin
        state_next      = frx_pkg::ST_HUNT;
        prefix_run_next = 4'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= frx_pkg::ST_HUNT;
      prefix_run   <= 4'd0;
      previous_rx  <= 8'd0;
      length_high  <= 8'd0;
      frame_length <= 16'd0;
      data_idx     <= 16'd0;
      running_xor  <= 8'd0;
      good_frames  <= 16'd0;
    end else if (step) begin
      state        <= state_next;
      prefix_run   <= prefix_run_next;
      previous_rx  <= rx_byte;
      length_high  <= length_high_next;
      frame_length <= frame_length_next;
      data_idx     <= data_idx_next;
      running_xor  <= running_xor_next;
      good_frames  <= good_frames_next;
    end
  end

endmodule

// ===== sv/prefixed_frame_receiver.sv =====
// A payload byte passes through the input register and then the result register,
// which holds its result beat until out_ready takes it.
// Throughput: one byte per cycle; the input register and the result register
// decouple the two channels, and a stall on the result side stalls the input.
// Reset (rst, synchronous): hunting, counters cleared, prefix_value 170, length 2.
// Depends on frx_pkg, frx_cfg and frx_parse.
`timescale 1ns / 1ps

module prefixed_frame_receiver (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [frx_pkg::ADDR_W-1:0]  paddr,
  input  logic [frx_pkg::DATA_W-1:0]  pwdata,
  output logic [frx_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        rx_valid,
  output logic                        rx_ready,
  input  logic [7:0]                  rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  payload_byte,
  output logic                        last_of_frame,
  output logic                        check_ok,
  output logic [15:0]                 frame_count
);

  frx_pkg::cfg_t cfg;
  frx_pkg::res_t res;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_step;

  frx_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The held byte is processed once the result register can take a beat.
  assign s1_step  = s1_valid && (!out_valid || out_ready);
  assign rx_ready = !s1_valid || s1_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx_valid && rx_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      s1_byte <= rx_byte;
    end
  end

  frx_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_step),
    .rx_byte (s1_byte),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_step && res.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_step && res.emit) begin
      payload_byte  <= res.payload_byte;
      last_of_frame <= res.last_of_frame;
      check_ok      <= res.check_ok;
      frame_count   <= res.frame_count;
    end
  end

  a_ok_only_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && check_ok |-> last_of_frame)
    else $error("check_ok raised on a beat that is not the last of its frame");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> rx_ready)
    else $error("input stalled while the input register is empty");

  a_held_byte_kept: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_step |=> s1_valid && $stable(s1_byte))
    else $error("held byte lost or changed before it was processed");

endmodule
